// ----- sv/tpq_pkg.sv -----
// Package for the timestamp priority queue: sizes, codes and the
// transfer, entry and cell command types. No dependencies.
package tpq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FILL_W = 5;

  typedef enum logic [1:0] {
    MODE_ENQ   = 2'd0,
    MODE_DEQ   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] event_time;
    logic [2:0]  event_kind;
    logic [15:0] order_id;
    logic [31:0] payload_ref;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              head_valid;
    logic [31:0]       head_time;
    logic [2:0]        head_kind;
    logic [15:0]       head_order;
    logic [31:0]       head_ref;
    logic [FILL_W-1:0] fill_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] ev_time;
    logic [2:0]  kind;
    logic [15:0] order;
    logic [31:0] ref_id;
  } entry_t;

  typedef struct packed {
    logic   shift_in;
    logic   shift_out;
    entry_t item;
  } cell_cmd_t;

endpackage

// ----- sv/timestamp_priority_queue.sv -----
// Timestamp priority queue top level: a row of tpq_cell slots plus
// the fill count and the result register. Depends on tpq_pkg, tpq_cell.
//
// Usage:
//   Requests arrive on req (req_valid / req_stall); each carries a mode:
//   enqueue, dequeue, peek or clear. Every request gives one response on
//   rsp (rsp_valid / rsp_stall) with status, the head event where one is
//   returned, and the fill count after the request.
//   Slots are kept sorted by time, slot 0 earliest; ties keep arrival
//   order. All slots compare against the incoming time in parallel and
//   shift together, so a request completes in the cycle it is taken.
//   The response is registered and is valid in the cycle after the request transfer.
//   Throughput: one request per cycle while responses are taken; the
//   limit is the single response register.
//   While a response waits under rsp_stall, req_stall is high and no
//   request is taken; the queue contents hold.
//   Reset empties the queue (fill count zero) and drops any pending
//   response. Slot contents are not cleared and are never read unless
//   written.
module timestamp_priority_queue import tpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic [CNT_W-1:0] count, count_next;
  logic             acc;
  logic             is_enq, is_deq, is_peek, is_clear;
  logic             full, empty, enq_ok, deq_ok;
  cell_cmd_t        cmd;
  entry_t           slot  [DEPTH];
  logic             after [DEPTH];
  rsp_t             rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign acc       = req_valid && !req_stall;

  assign is_enq   = req.mode == MODE_ENQ;
  assign is_deq   = req.mode == MODE_DEQ;
  assign is_peek  = req.mode == MODE_PEEK;
  assign is_clear = req.mode == MODE_CLEAR;

  assign full   = count == CNT_W'(DEPTH);
  assign empty  = count == '0;
  assign enq_ok = is_enq && !full;
  assign deq_ok = is_deq && !empty;

  assign cmd.shift_in     = acc && enq_ok;
  assign cmd.shift_out    = acc && deq_ok;
  assign cmd.item.ev_time = req.event_time;
  assign cmd.item.kind    = req.event_kind;
  assign cmd.item.order   = req.order_id;
  assign cmd.item.ref_id  = req.payload_ref;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tpq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (CNT_W'(i) < count),
      .prev_after ((i == 0) ? 1'b1 : after[(i == 0) ? 0 : i - 1]),
      .prev_entry (slot[(i == 0) ? 0 : i - 1]),
      .next_entry (slot[(i == DEPTH - 1) ? i : i + 1]),
      .entry      (slot[i]),
      .after      (after[i])
    );
  end

  always_comb begin
    count_next = count;
    if (is_clear) begin
      count_next = '0;
    end else if (enq_ok) begin
      count_next = count + 1'b1;
    end else if (deq_ok) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    rsp_next            = '0;
    rsp_next.status     = STATUS_OK;
    rsp_next.fill_count = FILL_W'(count_next);
    if (is_enq && full) begin
      rsp_next.status = STATUS_FULL;
    end else if ((is_deq || is_peek) && empty) begin
      rsp_next.status = STATUS_EMPTY;
    end else if (is_deq || is_peek) begin
      rsp_next.head_valid = 1'b1;
      rsp_next.head_time  = slot[0].ev_time;
      rsp_next.head_kind  = slot[0].kind;
      rsp_next.head_order = slot[0].order;
      rsp_next.head_ref   = slot[0].ref_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        count <= count_next;
      end
      if (acc) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> rsp_valid)
    else $error("no response after request transfer");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    acc && is_enq && full |=> $stable(count))
    else $error("dropped enqueue changed the fill count");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    acc && deq_ok |=> count == $past(count) - 1'b1)
    else $error("dequeue did not remove one entry");

  a_empty_nohead: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_EMPTY |-> !rsp.head_valid)
    else $error("empty response carries an event");
`endif

endmodule

// ----- sv/tpq_cell.sv -----
// One slot of the sorted shift-register queue.
// Depends on tpq_pkg.
module tpq_cell import tpq_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      prev_after,
  input  entry_t    prev_entry,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      after
);

  // new item goes behind this slot when it holds an equal or earlier time
  assign after = occupied && (entry.ev_time <= cmd.item.ev_time);

  always_ff @(posedge clk) begin
    if (cmd.shift_in && !after) begin
      entry <= prev_after ? cmd.item : prev_entry;
    end else if (cmd.shift_out) begin
      entry <= next_entry;
    end
  end

endmodule

// ----- tb/timestamp_priority_queue_tb.sv -----
// Testbench for timestamp_priority_queue: directed and random requests checked
// against a sorted-list predictor of the queue. Depends on tpq_pkg and the RTL.
`timescale 1ns / 100ps

module timestamp_priority_queue_tb;
  import tpq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  entry_t model_slot [DEPTH];
  int model_fill = 0;
  rsp_t pending_rsp [$];
  int errors = 0;
  bit no_idle = 1'b0;
  logic [31:0] recent_time = 32'h0;

  timestamp_priority_queue uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    rsp_stall <= !no_idle && ($urandom_range(99) < 8);
  end

  // Expected response for one request; updates the predicted queue contents.
  function automatic rsp_t apply_to_model(req_t r);
    rsp_t res;
    int pos;
    int i;
    entry_t e;
    res = '0;
    e.ev_time = r.event_time;
    e.kind = r.event_kind;
    e.order = r.order_id;
    e.ref_id = r.payload_ref;
    case (mode_e'(r.mode))
      MODE_ENQ: begin
        if (model_fill >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < model_fill && model_slot[pos].ev_time <= r.event_time) pos++;
          for (i = model_fill; i > pos; i--) model_slot[i] = model_slot[i-1];
          model_slot[pos] = e;
          model_fill++;
        end
      end
      MODE_DEQ, MODE_PEEK: begin
        if (model_fill == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.status = STATUS_OK;
          res.head_valid = 1'b1;
          res.head_time = model_slot[0].ev_time;
          res.head_kind = model_slot[0].kind;
          res.head_order = model_slot[0].order;
          res.head_ref = model_slot[0].ref_id;
          if (mode_e'(r.mode) == MODE_DEQ) begin
            for (i = 1; i < model_fill; i++) model_slot[i-1] = model_slot[i];
            model_fill--;
          end
        end
      end
      default: begin
        model_fill = 0;
      end
    endcase
    res.fill_count = FILL_W'(model_fill);
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // rsp_stall only changes at the rising edge, so a transfer seen here
  // completes at the next edge.
  always @(negedge clk) begin : rsp_checker
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %h", $time, rsp);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        compare_field("status", 32'(want.status), 32'(rsp.status));
        compare_field("head_valid", 32'(want.head_valid), 32'(rsp.head_valid));
        compare_field("head_time", want.head_time, rsp.head_time);
        compare_field("head_kind", 32'(want.head_kind), 32'(rsp.head_kind));
        compare_field("head_order", 32'(want.head_order), 32'(rsp.head_order));
        compare_field("head_ref", want.head_ref, rsp.head_ref);
        compare_field("fill_count", 32'(want.fill_count), 32'(rsp.fill_count));
      end
    end
  end

  task automatic send_request(req_t r);
    int gap;
    gap = 0;
    if (!no_idle) while ($urandom_range(99) < 8) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(negedge clk);
    while (req_stall !== 1'b0) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    pending_rsp.push_back(apply_to_model(r));
  endtask

  task automatic wait_for_responses();
    int guard;
    guard = 0;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_rsp.size() != 0) begin
      $display("%0t: responses missing, expected %0d actual 0", $time, pending_rsp.size());
      errors++;
      pending_rsp.delete();
    end
  endtask

  function automatic req_t make_req(mode_e m, logic [31:0] t, logic [2:0] k,
                                    logic [15:0] o, logic [31:0] pref);
    req_t r;
    r.mode = m;
    r.event_time = t;
    r.event_kind = k;
    r.order_id = o;
    r.payload_ref = pref;
    return r;
  endfunction

  // Mix of full-range times, small integer times, the extreme values and repeats so ties are common.
  function automatic logic [31:0] pick_time();
    logic [31:0] t;
    case ($urandom_range(5))
      0: t = recent_time;
      1: t = {14'h0, 2'($urandom_range(3)), 16'h8000};
      2: t = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: t = $urandom;
    endcase
    recent_time = t;
    return t;
  endfunction

  task automatic random_phase(int n, int enq_pct, int deq_pct, int peek_pct);
    int roll;
    mode_e m;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < enq_pct) m = MODE_ENQ;
      else if (roll < enq_pct + deq_pct) m = MODE_DEQ;
      else if (roll < enq_pct + deq_pct + peek_pct) m = MODE_PEEK;
      else m = MODE_CLEAR;
      send_request(make_req(m, pick_time(), 3'($urandom), 16'($urandom), $urandom));
    end
  endtask

  task automatic test_empty_queue();
    send_request(make_req(MODE_DEQ, 32'hFFFF_FFFF, 3'h7, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_req(MODE_PEEK, 32'h0, 3'h0, 16'h0, 32'h0));
  endtask

  task automatic test_fill_to_capacity();
    int i;
    send_request(make_req(MODE_ENQ, 32'h0005_8000, 3'h1, 16'h0001, 32'h1111_0001));
    send_request(make_req(MODE_ENQ, 32'hFFFF_FFFF, 3'h7, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_req(MODE_ENQ, 32'h0, 3'h0, 16'h0, 32'h0));
    send_request(make_req(MODE_ENQ, 32'h0005_8000, 3'h2, 16'h0002, 32'h1111_0002));
    send_request(make_req(MODE_ENQ, 32'h0005_8000, 3'h3, 16'h0003, 32'h1111_0003));
    for (i = 0; i < 11; i++) begin
      send_request(make_req(MODE_ENQ, 32'h0001_0000 * (i % 4) + 32'h8000, 3'(i),
                            16'h0100 + 16'(i), 32'hA5A5_0000 | i));
    end
    // queue is full: this one is dropped even though no queued time is earlier
    send_request(make_req(MODE_ENQ, 32'h0, 3'h5, 16'hDEAD, 32'hDEAD_BEEF));
  endtask

  task automatic test_head_access();
    send_request(make_req(MODE_PEEK, 32'h0, 3'h0, 16'h0, 32'h0));
    send_request(make_req(MODE_DEQ, 32'h0, 3'h0, 16'h0, 32'h0));
    send_request(make_req(MODE_DEQ, 32'h0, 3'h0, 16'h0, 32'h0));
  endtask

  task automatic test_clear();
    send_request(make_req(MODE_CLEAR, 32'hFFFF_FFFF, 3'h7, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_req(MODE_DEQ, 32'h0, 3'h0, 16'h0, 32'h0));
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    random_phase(150, 50, 35, 12);
    no_idle = 1'b0;
  endtask

  task automatic test_fill_drain_cycles();
    repeat (6) begin
      random_phase(45, 80, 12, 6);
      random_phase(45, 15, 65, 18);
    end
  endtask

  task automatic test_random_mix();
    random_phase(120, 35, 30, 25);
  endtask

  task automatic test_pause_until_drained();
    random_phase(20, 70, 20, 8);
    wait_for_responses();
    random_phase(20, 30, 50, 18);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_to_capacity();
    test_head_access();
    test_clear();
    test_back_to_back();
    test_fill_drain_cycles();
    test_random_mix();
    test_pause_until_drained();
    wait_for_responses();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
